// ===== rtl/tnws_pkg.sv =====
// Shared types, status codes and widths for the two-nearest winner search.
package tnws_pkg;

  localparam int DEFAULT_ENTRIES = 4096;
  localparam int DIMS            = 4;
  localparam int COORD_W         = 16;
  localparam int DIFF_W          = COORD_W + 1;
  localparam int SQ_W            = 2 * COORD_W;
  localparam int DIST_W          = 34;
  localparam int IDX_IN_W        = 12;
  localparam int IDX_OUT_W       = 13;
  localparam int POINT_W         = DIMS * COORD_W;

  localparam logic [DIST_W-1:0] NO_DISTANCE = {DIST_W{1'b1}};

  // Entry status codes
  localparam logic [1:0] ST_INACTIVE = 2'd0;
  localparam logic [1:0] ST_ACTIVE   = 2'd1;
  localparam logic [1:0] ST_END      = 2'd2;
  localparam logic [1:0] ST_SPARE    = 2'd3;

  // Item modes
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef logic [POINT_W-1:0] point_t;

  typedef struct packed {
    logic                       mode;
    logic [IDX_IN_W-1:0]        entry_index;
    logic signed [COORD_W-1:0]  coord_0;
    logic signed [COORD_W-1:0]  coord_1;
    logic signed [COORD_W-1:0]  coord_2;
    logic signed [COORD_W-1:0]  coord_3;
    logic [1:0]                 entry_status;
  } in_item_t;

  typedef struct packed {
    logic [IDX_OUT_W-1:0] first_index;
    logic [DIST_W-1:0]    first_distance;
    logic [IDX_OUT_W-1:0] second_index;
    logic [DIST_W-1:0]    second_distance;
  } out_item_t;

  // Write request into the landmark store
  typedef struct packed {
    logic       we;
    logic       point_we;
    logic [1:0] status;
    point_t     point;
  } st_wr_t;

endpackage

// ===== rtl/tnws_store.sv =====
// Landmark point and status memories with one write port and one registered read port.
module tnws_store import tnws_pkg::*; #(
  parameter int ENTRIES = DEFAULT_ENTRIES,
  parameter int AW      = $clog2(ENTRIES)
) (
  input  logic          clk,
  input  st_wr_t        wr,
  input  logic [AW-1:0] waddr,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [1:0]    rstatus,
  output point_t        rpoint
);

  logic [1:0] status_mem [ENTRIES];
  point_t     point_mem  [ENTRIES];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      status_mem[waddr] <= wr.status;
    end
    if (wr.point_we) begin
      point_mem[waddr] <= wr.point;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rstatus <= status_mem[raddr];
      rpoint  <= point_mem[raddr];
    end
  end

endmodule

// ===== rtl/tnws_dist.sv =====
// Two-stage squared Euclidean distance unit, one landmark per cycle.
module tnws_dist import tnws_pkg::*; #(
  parameter int AW = 12
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [AW-1:0]     in_idx,
  input  point_t            sample,
  input  point_t            point,
  output logic              pending,
  output logic              out_valid,
  output logic [AW-1:0]     out_idx,
  output logic [DIST_W-1:0] out_dist
);

  logic              sq_valid;
  logic [AW-1:0]     sq_idx;
  logic [SQ_W-1:0]   sq [DIMS];
  logic [SQ_W-1:0]   sq_next [DIMS];

  // Subtract and square each coordinate
  always_comb begin
    logic signed [DIFF_W-1:0]   diff;
    logic signed [2*DIFF_W-1:0] prod;
    for (int k = 0; k < DIMS; k++) begin
      diff = DIFF_W'(signed'(sample[k*COORD_W +: COORD_W]))
           - DIFF_W'(signed'(point[k*COORD_W +: COORD_W]));
      prod = diff * diff;
      sq_next[k] = prod[SQ_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      sq_valid  <= in_valid;
      out_valid <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    sq_idx  <= in_idx;
    sq      <= sq_next;
    out_idx <= sq_idx;
    out_dist <= DIST_W'(sq[0]) + DIST_W'(sq[1]) + DIST_W'(sq[2]) + DIST_W'(sq[3]);
  end

  assign pending = sq_valid | out_valid;

endmodule

// ===== rtl/tnws_rank.sv =====
// Keeps the nearest and second-nearest winners of a scan; earlier entry wins ties.
module tnws_rank import tnws_pkg::*; #(
  parameter int ENTRIES = DEFAULT_ENTRIES,
  parameter int AW      = $clog2(ENTRIES),
  parameter int CW      = $clog2(ENTRIES + 1)
) (
  input  logic              clk,
  input  logic              clear,
  input  logic              valid,
  input  logic [AW-1:0]     idx,
  input  logic [DIST_W-1:0] cand_dist,
  output logic [CW-1:0]     i1,
  output logic [DIST_W-1:0] d1,
  output logic [CW-1:0]     i2,
  output logic [DIST_W-1:0] d2
);

  always_ff @(posedge clk) begin
    if (clear) begin
      i1 <= CW'(ENTRIES);
      d1 <= NO_DISTANCE;
      i2 <= CW'(ENTRIES);
      d2 <= NO_DISTANCE;
    end else if (valid) begin
      if (cand_dist < d1) begin
        i2 <= i1;
        d2 <= d1;
        i1 <= CW'(idx);
        d1 <= cand_dist;
      end else if (cand_dist < d2) begin
        i2 <= CW'(idx);
        d2 <= cand_dist;
      end
    end
  end

endmodule

// ===== rtl/two_nearest_winner_search_core.sv =====
// Top level of the two-nearest winner search: sequencer, store, distance unit, ranking.
//
//   channel   signals              direction  accepted when
//   command   start, item, busy    in         start & !busy at the rising edge
//   result    done, result         out        done high for one cycle, no stall
//
// A write item is written to the store at its accept edge and busy stays low. A
// query item walks the store one entry per cycle through the two-stage distance
// unit, up to and including the first end-of-data entry, or all ENTRIES entries
// when none ends the scan; busy stays high until the distance unit has drained
// behind the last active entry. done pulses in the first cycle with busy low again.
// After reset the status memory is swept to end-of-data with busy high. The
// receiver cannot stall results.
module two_nearest_winner_search_core import tnws_pkg::*; #(
  parameter int ENTRIES = DEFAULT_ENTRIES
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  in_item_t  item,
  output logic      busy,
  output logic      done,
  output out_item_t result
);

  localparam int AW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_SCAN} state_t;

  state_t          state;
  logic [CW-1:0]   cnt;      // clear sweep address, then scan read address
  logic            stop;     // no more reads to issue for this query
  logic            v1;       // read data of entry idx1 is valid this cycle
  logic [AW-1:0]   idx1;
  point_t          sample;

  logic            accept;
  logic            do_write;
  logic            issue;
  logic            hit_end;
  logic            hit_act;
  logic            drained;
  st_wr_t          wr;
  logic [AW-1:0]   waddr;
  logic [1:0]      rstatus;
  point_t          rpoint;
  point_t          in_point;

  logic            dist_pending;
  logic            dist_valid;
  logic [AW-1:0]   dist_idx;
  logic [DIST_W-1:0] cand_dist;
  logic [CW-1:0]   i1;
  logic [CW-1:0]   i2;
  logic [DIST_W-1:0] d1;
  logic [DIST_W-1:0] d2;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // Drop writes beyond the table.
  assign do_write = accept && (item.mode == MODE_WRITE)
                    && (32'(item.entry_index) < 32'(ENTRIES));

  assign in_point = {item.coord_3, item.coord_2, item.coord_1, item.coord_0};

  // Store write port: the clear sweep touches the status only.
  always_comb begin
    wr.we       = do_write || (state == S_CLEAR);
    wr.point_we = do_write;
    wr.point    = in_point;
    if (state == S_CLEAR) begin
      wr.status = ST_END;
      waddr     = cnt[AW-1:0];
    end else begin
      wr.status = (item.entry_status == ST_SPARE) ? ST_END : item.entry_status;
      waddr     = AW'(item.entry_index);
    end
  end

  assign issue   = (state == S_SCAN) && !stop;
  // The spare code counts as end of data.
  assign hit_end = v1 && ((rstatus == ST_END) || (rstatus == ST_SPARE));
  assign hit_act = v1 && (rstatus == ST_ACTIVE);
  assign drained = stop && !v1 && !dist_pending;

  tnws_store #(.ENTRIES(ENTRIES), .AW(AW)) u_store (
    .clk     (clk),
    .wr      (wr),
    .waddr   (waddr),
    .re      (issue),
    .raddr   (cnt[AW-1:0]),
    .rstatus (rstatus),
    .rpoint  (rpoint)
  );

  tnws_dist #(.AW(AW)) u_dist (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (hit_act),
    .in_idx    (idx1),
    .sample    (sample),
    .point     (rpoint),
    .pending   (dist_pending),
    .out_valid (dist_valid),
    .out_idx   (dist_idx),
    .out_dist  (cand_dist)
  );

  tnws_rank #(.ENTRIES(ENTRIES), .AW(AW), .CW(CW)) u_rank (
    .clk       (clk),
    .clear     (accept && (item.mode == MODE_QUERY)),
    .valid     (dist_valid),
    .idx       (dist_idx),
    .cand_dist (cand_dist),
    .i1        (i1),
    .d1        (d1),
    .i2        (i2),
    .d2        (d2)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      cnt   <= '0;
      stop  <= 1'b0;
      v1    <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      // Kill the read issued behind an end-of-data entry.
      v1   <= issue && !hit_end;
      idx1 <= cnt[AW-1:0];
      unique case (state)
        S_CLEAR: begin
          cnt <= cnt + 1'b1;
          if (cnt == CW'(ENTRIES - 1)) begin
            cnt   <= '0;
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept && (item.mode == MODE_QUERY)) begin
            cnt    <= '0;
            stop   <= 1'b0;
            sample <= in_point;
            state  <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (issue) begin
            cnt <= cnt + 1'b1;
            if (cnt == CW'(ENTRIES - 1)) begin
              stop <= 1'b1;
            end
          end
          if (hit_end) begin
            stop <= 1'b1;
          end
          if (drained) begin
            done                   <= 1'b1;
            result.first_index     <= IDX_OUT_W'(i1);
            result.first_distance  <= d1;
            result.second_index    <= IDX_OUT_W'(i2);
            result.second_distance <= d2;
            state                  <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== test/tnws_tb_pkg.sv =====
// Scoreboard for the two-nearest winner search: landmark table copy, ranking and result checks.
package tnws_tb_pkg;
  import tnws_pkg::*;

  class winner_scoreboard;
    logic signed [COORD_W-1:0] land_pt [DEFAULT_ENTRIES][DIMS];
    logic [1:0]                land_st [DEFAULT_ENTRIES];
    out_item_t                 pending [$];
    int                        errors;

    function new();
      foreach (land_st[j]) begin
        land_st[j] = ST_END;
        for (int k = 0; k < DIMS; k++) land_pt[j][k] = '0;
      end
      errors = 0;
    endfunction

    // Exact squared distance between the sample and landmark j.
    function logic [DIST_W-1:0] span_sq(in_item_t q, int j);
      longint s [DIMS];
      longint acc;
      longint d;
      s[0] = longint'($signed(q.coord_0));
      s[1] = longint'($signed(q.coord_1));
      s[2] = longint'($signed(q.coord_2));
      s[3] = longint'($signed(q.coord_3));
      acc = 0;
      for (int k = 0; k < DIMS; k++) begin
        d = s[k] - longint'(land_pt[j][k]);
        acc += d * d;
      end
      return acc[DIST_W-1:0];
    endfunction

    // Scan in index order up to the first end-of-data entry; strict compare keeps earlier on ties.
    function out_item_t rank_pair(in_item_t q);
      out_item_t r;
      logic [DIST_W-1:0] d;
      r.first_index     = IDX_OUT_W'(DEFAULT_ENTRIES);
      r.first_distance  = NO_DISTANCE;
      r.second_index    = IDX_OUT_W'(DEFAULT_ENTRIES);
      r.second_distance = NO_DISTANCE;
      for (int j = 0; j < DEFAULT_ENTRIES; j++) begin
        if (land_st[j] == ST_ACTIVE) begin
          d = span_sq(q, j);
          if (d < r.first_distance) begin
            r.second_index    = r.first_index;
            r.second_distance = r.first_distance;
            r.first_index     = IDX_OUT_W'(j);
            r.first_distance  = d;
          end else if (d < r.second_distance) begin
            r.second_index    = IDX_OUT_W'(j);
            r.second_distance = d;
          end
        end else if (land_st[j] != ST_INACTIVE) begin
          break;
        end
      end
      return r;
    endfunction

    function void note(in_item_t it);
      if (it.mode == MODE_WRITE) begin
        land_pt[it.entry_index][0] = it.coord_0;
        land_pt[it.entry_index][1] = it.coord_1;
        land_pt[it.entry_index][2] = it.coord_2;
        land_pt[it.entry_index][3] = it.coord_3;
        land_st[it.entry_index] = (it.entry_status == ST_SPARE) ? ST_END : it.entry_status;
      end else begin
        pending.push_back(rank_pair(it));
      end
    endfunction

    function void check(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        $error("result with no query pending: first_index %0d", got.first_index);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.first_index !== want.first_index) begin
        $error("first_index: expected %0d, actual %0d", want.first_index, got.first_index);
        errors++;
      end
      if (got.first_distance !== want.first_distance) begin
        $error("first_distance: expected %0d, actual %0d",
               want.first_distance, got.first_distance);
        errors++;
      end
      if (got.second_index !== want.second_index) begin
        $error("second_index: expected %0d, actual %0d", want.second_index, got.second_index);
        errors++;
      end
      if (got.second_distance !== want.second_distance) begin
        $error("second_distance: expected %0d, actual %0d",
               want.second_distance, got.second_distance);
        errors++;
      end
    endfunction
  endclass

endpackage

// ===== test/tb_two_nearest_winner_search_core.sv =====
// Testbench for the two-nearest winner search core: directed and random items, scoreboard checks.
module tb_two_nearest_winner_search_core;
  import tnws_pkg::*;
  import tnws_tb_pkg::*;

  // Longest quiet stretch of a correct run is a full store scan or the reset sweep;
  // allow several times that.
  localparam int STALL_LIMIT = 20000;
  localparam int RAND_ITEMS  = 116;

  logic      clk   = 1'b0;
  logic      rst   = 1'b1;
  logic      start = 1'b0;
  in_item_t  item  = '0;
  logic      busy;
  logic      done;
  out_item_t result;

  winner_scoreboard sb;
  int               idle_pct = 0;
  int               stall_cycles = 0;
  in_item_t         last_write = '0;

  two_nearest_winner_search_core i_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .item   (item),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  always #10 clk = ~clk;

  // Check every result strobe against the oldest pending prediction.
  always @(posedge clk) begin
    if (!rst && done) sb.check(result);
  end

  // Count cycles in which neither an item nor a result moves; bail out on a hang.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("[two_nearest_winner_search_core] ERROR");
      $finish;
    end
  end

  function automatic in_item_t mk_item(logic m, logic [IDX_IN_W-1:0] idx,
                                       logic [COORD_W-1:0] c0, logic [COORD_W-1:0] c1,
                                       logic [COORD_W-1:0] c2, logic [COORD_W-1:0] c3,
                                       logic [1:0] st);
    in_item_t it;
    it.mode         = m;
    it.entry_index  = idx;
    it.coord_0      = c0;
    it.coord_1      = c1;
    it.coord_2      = c2;
    it.coord_3      = c3;
    it.entry_status = st;
    return it;
  endfunction

  // Favor the extremes and a cluster near zero so close calls and ties show up.
  function automatic logic [COORD_W-1:0] pick_coord();
    case ($urandom_range(0, 5))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return COORD_W'($urandom_range(0, 15)) - 16'd8;
      default: return COORD_W'($urandom);
    endcase
  endfunction

  // Mostly writes into a small low region so scans stay short, about one query in four.
  function automatic in_item_t random_item();
    in_item_t it;
    int       r;
    it.coord_0 = pick_coord();
    it.coord_1 = pick_coord();
    it.coord_2 = pick_coord();
    it.coord_3 = pick_coord();
    if ($urandom_range(0, 99) < 25) begin
      it.mode         = MODE_QUERY;
      it.entry_index  = IDX_IN_W'($urandom);
      it.entry_status = 2'($urandom);
    end else begin
      it.mode = MODE_WRITE;
      // an occasional write far up the table toggles the high index bits
      if ($urandom_range(0, 99) < 8) begin
        it.entry_index = IDX_IN_W'($urandom);
      end else begin
        it.entry_index = IDX_IN_W'($urandom_range(0, 15));
      end
      r = $urandom_range(0, 99);
      if (r < 60)      it.entry_status = ST_ACTIVE;
      else if (r < 85) it.entry_status = ST_INACTIVE;
      else if (r < 95) it.entry_status = ST_END;
      else             it.entry_status = ST_SPARE;
      // reuse the previous landmark now and then to force equal distances
      if ($urandom_range(0, 99) < 15) begin
        it.coord_0 = last_write.coord_0;
        it.coord_1 = last_write.coord_1;
        it.coord_2 = last_write.coord_2;
        it.coord_3 = last_write.coord_3;
      end
    end
    return it;
  endfunction

  // Drive one item from the falling edge; hold it until an edge with busy low takes it.
  task automatic send_item(input in_item_t it);
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy);
    sb.note(it);
    if (it.mode == MODE_WRITE) last_write = it;
  endtask

  initial begin
    sb = new();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part: empty table, extreme distance, ties, hidden entries, masking end marks.
    send_item(mk_item(MODE_QUERY, 12'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, ST_INACTIVE));
    send_item(mk_item(MODE_WRITE, 12'd0, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, ST_ACTIVE));
    send_item(mk_item(MODE_QUERY, 12'd0, 16'h8000, 16'h8000, 16'h8000, 16'h8000, ST_ACTIVE));
    send_item(mk_item(MODE_WRITE, 12'd1, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, ST_ACTIVE));
    send_item(mk_item(MODE_QUERY, 12'd5, 16'h0000, 16'h0000, 16'h0000, 16'h0000, ST_END));
    send_item(mk_item(MODE_WRITE, 12'd2, 16'h0000, 16'h0000, 16'h0000, 16'h0000, ST_INACTIVE));
    send_item(mk_item(MODE_WRITE, 12'd3, 16'h0000, 16'h0000, 16'h0000, 16'h0000, ST_ACTIVE));
    send_item(mk_item(MODE_QUERY, 12'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, ST_SPARE));
    // the spare code ends the scan, so entry 5 stays hidden
    send_item(mk_item(MODE_WRITE, 12'd4, 16'h8000, 16'h8000, 16'h8000, 16'h8000, ST_SPARE));
    send_item(mk_item(MODE_WRITE, 12'd5, 16'h8000, 16'h8000, 16'h8000, 16'h8000, ST_ACTIVE));
    send_item(mk_item(MODE_QUERY, 12'd0, 16'h8000, 16'h8000, 16'h8000, 16'h8000, ST_ACTIVE));
    send_item(mk_item(MODE_WRITE, 12'd4, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, ST_ACTIVE));
    send_item(mk_item(MODE_QUERY, 12'd0, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, ST_INACTIVE));
    send_item(mk_item(MODE_WRITE, 12'd6, 16'h1234, 16'hedcb, 16'h0001, 16'hffff, ST_END));
    send_item(mk_item(MODE_WRITE, 12'hfff, 16'h0000, 16'h0000, 16'h0000, 16'h0000, ST_ACTIVE));
    send_item(mk_item(MODE_WRITE, 12'haaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa, ST_INACTIVE));
    send_item(mk_item(MODE_WRITE, 12'h555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, ST_END));
    send_item(mk_item(MODE_WRITE, 12'd0, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, ST_INACTIVE));
    // query fields that a query ignores are set to all ones
    send_item(mk_item(MODE_QUERY, 12'hfff, 16'h0001, 16'hffff, 16'h0002, 16'hfffe, ST_SPARE));
    send_item(mk_item(MODE_WRITE, 12'd3, 16'h0000, 16'h0000, 16'h0000, 16'h0000, ST_INACTIVE));
    send_item(mk_item(MODE_WRITE, 12'd4, 16'h0000, 16'h0000, 16'h0000, 16'h0000, ST_INACTIVE));
    send_item(mk_item(MODE_QUERY, 12'd0, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, ST_ACTIVE));
    send_item(mk_item(MODE_WRITE, 12'd1, 16'h0000, 16'h0000, 16'h0000, 16'h0000, ST_INACTIVE));
    send_item(mk_item(MODE_QUERY, 12'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, ST_ACTIVE));

    // Random part in three pacing phases: back to back, sparse, and moderate.
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == RAND_ITEMS / 3)     idle_pct = 75;
      if (n == 2 * RAND_ITEMS / 3) idle_pct = 31;
      send_item(random_item());
    end
    @(negedge clk);
    start <= 1'b0;

    // Drain: wait for the last query result, then keep watching for stray strobes.
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("[two_nearest_winner_search_core] OK");
    end else begin
      $display("[two_nearest_winner_search_core] ERROR");
    end
    $finish;
  end

endmodule
